// ----- src/i2c_mra_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master register access: shared package
// Types, codes and constants that are shared by the front, back and core
// modules of the register access engine and by its testbench.
// ----------------------------------------------------------------------------
package i2c_mra_pkg;

  // Default depth of the item and result queues.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Reset value of the ACK timeout register.
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  // Raw command codes on the input port.
  localparam logic [1:0] CMD_CODE_TICK   = 2'd0;
  localparam logic [1:0] CMD_CODE_WRITE  = 2'd1;
  localparam logic [1:0] CMD_CODE_READ   = 2'd2;
  localparam logic [1:0] CMD_CODE_SUPPLY = 2'd3;

  // Command class as decoded by the front.
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_BEGIN_WRITE,
    KIND_BEGIN_READ,
    KIND_SUPPLY
  } kind_t;

  // Pin phase of the bit engine.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_ST_C,
    PH_RS_PREP,
    PH_TX_LO,
    PH_TX_HI,
    PH_ACK_LO,
    PH_ACK_HI,
    PH_WAIT_BYTE,
    PH_RX_LO,
    PH_RX_HI,
    PH_MACK_LO,
    PH_MACK_HI,
    PH_SP_A,
    PH_SP_B
  } phase_t;

  // Which byte of the transaction is on the wire.
  typedef enum logic [1:0] {
    STG_ADDR_W,
    STG_REG,
    STG_ADDR_R,
    STG_DATA
  } stage_t;

  // One classified input item.
  typedef struct packed {
    kind_t      kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       need_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_read;
    logic       ack_error;
    logic       done_res;
  } result_t;

endpackage

// ----- src/i2c_mra_fifo.sv -----
// ----------------------------------------------------------------------------
// I2C master register access: register queue
// Small first-in first-out queue built from flip-flops, with push/full on
// the write side and pop/empty on the read side.
// ----------------------------------------------------------------------------
module i2c_mra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- src/i2c_mra_front.sv -----
// ----------------------------------------------------------------------------
// I2C master register access: front end
// Accepts input items, decodes the command code into a command class and
// holds the classified items in a short queue for the bit engine.
// ----------------------------------------------------------------------------
module i2c_mra_front
  import i2c_mra_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd,
  input  logic [6:0] dev_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] byte_count,
  input  logic [7:0] write_byte,
  input  logic       sda_in,
  output item_t      item,
  output logic       item_avail,
  input  logic       item_take
);

  item_t in_item;
  logic  q_empty;

  // Command decode.
  always_comb begin
    in_item.dev_addr   = dev_addr;
    in_item.reg_addr   = reg_addr;
    in_item.byte_count = byte_count;
    in_item.write_byte = write_byte;
    in_item.sda_in     = sda_in;
    unique case (cmd)
      CMD_CODE_WRITE:  in_item.kind = KIND_BEGIN_WRITE;
      CMD_CODE_READ:   in_item.kind = KIND_BEGIN_READ;
      CMD_CODE_SUPPLY: in_item.kind = KIND_SUPPLY;
      default:         in_item.kind = KIND_TICK;
    endcase
  end

  // Queue between the front and the bit engine.
  i2c_mra_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (in_item),
    .full    (full),
    .pop     (item_take),
    .rd_data (item),
    .empty   (q_empty)
  );

  assign item_avail = !q_empty;

endmodule

// ----- src/i2c_mra_back.sv -----
// ----------------------------------------------------------------------------
// I2C master register access: bit engine
// Steps the I2C phase machine by at most one pin phase per item and queues one
// result per item for the host.
// ----------------------------------------------------------------------------
module i2c_mra_back
  import i2c_mra_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       item_avail,
  output logic       item_take,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       pop,
  output logic       empty,
  output result_t    result
);

  phase_t     phase, phase_next;
  stage_t     stage, stage_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [6:0] device_reg, device_reg_next;
  logic [7:0] register_reg, register_reg_next;
  logic       reading, reading_next;
  logic [7:0] wait_count, wait_count_next;
  logic       error_flag, error_flag_next;
  logic [7:0] ack_timeout;
  logic       out_full;
  logic       fire;
  logic       ack_ok;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign fire      = item_avail && !out_full;
  assign item_take = fire;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout <= cfg_data;
    end
  end

  // Engine state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      stage        <= STG_ADDR_W;
      bit_index    <= '0;
      shift_reg    <= '0;
      bytes_left   <= '0;
      device_reg   <= '0;
      register_reg <= '0;
      reading      <= 1'b0;
      wait_count   <= '0;
      error_flag   <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      stage        <= stage_next;
      bit_index    <= bit_index_next;
      shift_reg    <= shift_reg_next;
      bytes_left   <= bytes_left_next;
      device_reg   <= device_reg_next;
      register_reg <= register_reg_next;
      reading      <= reading_next;
      wait_count   <= wait_count_next;
      error_flag   <= error_flag_next;
    end
  end

  // Next phase and the pin levels of the new phase.
  always_comb begin
    phase_next        = phase;
    stage_next        = stage;
    bit_index_next    = bit_index;
    shift_reg_next    = shift_reg;
    bytes_left_next   = bytes_left;
    device_reg_next   = device_reg;
    register_reg_next = register_reg;
    reading_next      = reading;
    wait_count_next   = wait_count;
    error_flag_next   = error_flag;
    ack_ok            = 1'b0;
    res               = '0;

    unique case (phase)
      PH_IDLE: begin
        if (item.kind == KIND_BEGIN_WRITE || item.kind == KIND_BEGIN_READ) begin
          device_reg_next   = item.dev_addr;
          register_reg_next = item.reg_addr;
          bytes_left_next   = item.byte_count;
          reading_next      = (item.kind == KIND_BEGIN_READ);
          error_flag_next   = 1'b0;
          wait_count_next   = '0;
          stage_next        = STG_ADDR_W;
          shift_reg_next    = {item.dev_addr, 1'b0};
          bit_index_next    = '0;
          phase_next        = PH_ST_A;
        end
      end
      PH_ST_A:    phase_next = PH_ST_B;
      PH_ST_B:    phase_next = PH_ST_C;
      PH_ST_C:    phase_next = PH_TX_LO;
      PH_RS_PREP: phase_next = PH_ST_A;
      PH_TX_LO:   phase_next = PH_TX_HI;
      PH_TX_HI: begin
        if (bit_index == 3'd7) begin
          bit_index_next  = '0;
          wait_count_next = '0;
          phase_next      = PH_ACK_LO;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = PH_TX_LO;
        end
      end
      PH_ACK_LO: phase_next = PH_ACK_HI;
      PH_ACK_HI: begin
        // A low SDA is an ACK; a long enough high run flags an error and moves on.
        if (!item.sda_in) begin
          ack_ok = 1'b1;
        end else if (wait_count >= ack_timeout) begin
          error_flag_next = 1'b1;
          ack_ok          = 1'b1;
        end else begin
          wait_count_next = wait_count + 8'd1;
        end
        if (ack_ok) begin
          unique case (stage)
            STG_ADDR_W: begin
              shift_reg_next = register_reg;
              bit_index_next = '0;
              stage_next     = STG_REG;
              phase_next     = PH_TX_LO;
            end
            STG_REG: begin
              if (reading) begin
                shift_reg_next = {device_reg, 1'b1};
                bit_index_next = '0;
                stage_next     = STG_ADDR_R;
                phase_next     = PH_RS_PREP;
              end else begin
                stage_next = STG_DATA;
                phase_next = (bytes_left != '0) ? PH_WAIT_BYTE : PH_SP_A;
              end
            end
            STG_ADDR_R: begin
              if (bytes_left != '0) begin
                shift_reg_next = '0;
                bit_index_next = '0;
                phase_next     = PH_RX_LO;
              end else begin
                phase_next = PH_SP_A;
              end
            end
            default: begin
              phase_next = (bytes_left != '0) ? PH_WAIT_BYTE : PH_SP_A;
            end
          endcase
        end
      end
      PH_WAIT_BYTE: begin
        if (item.kind == KIND_SUPPLY) begin
          shift_reg_next  = item.write_byte;
          bytes_left_next = bytes_left - 8'd1;
          bit_index_next  = '0;
          phase_next      = PH_TX_LO;
        end
      end
      PH_RX_LO: phase_next = PH_RX_HI;
      PH_RX_HI: begin
        // Data arrives MSB first.
        shift_reg_next[~bit_index] = shift_reg[~bit_index] | item.sda_in;
        if (bit_index == 3'd7) begin
          bytes_left_next = bytes_left - 8'd1;
          res.read_valid  = 1'b1;
          res.last_read   = (bytes_left_next == '0);
          bit_index_next  = '0;
          phase_next      = PH_MACK_LO;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = PH_RX_LO;
        end
      end
      PH_MACK_LO: phase_next = PH_MACK_HI;
      PH_MACK_HI: begin
        if (bytes_left != '0) begin
          shift_reg_next = '0;
          bit_index_next = '0;
          phase_next     = PH_RX_LO;
        end else begin
          phase_next = PH_SP_A;
        end
      end
      PH_SP_A: phase_next = PH_SP_B;
      PH_SP_B: begin
        phase_next   = PH_IDLE;
        res.done_res = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase

    // Line levels of the phase just entered.
    res.scl = 1'b1;
    res.sda = 1'b1;
    unique case (phase_next)
      PH_ST_B: begin
        res.sda = 1'b0;
      end
      PH_ST_C, PH_SP_A: begin
        res.scl = 1'b0;
        res.sda = 1'b0;
      end
      PH_RS_PREP, PH_ACK_LO, PH_RX_LO: begin
        res.scl = 1'b0;
      end
      PH_TX_LO: begin
        res.scl = 1'b0;
        res.sda = shift_reg_next[~bit_index_next];
      end
      PH_TX_HI: begin
        res.sda = shift_reg_next[~bit_index_next];
      end
      PH_WAIT_BYTE: begin
        res.scl       = 1'b0;
        res.need_byte = 1'b1;
      end
      PH_MACK_LO: begin
        res.scl = 1'b0;
        res.sda = (bytes_left_next == '0);
      end
      PH_MACK_HI: begin
        res.sda = (bytes_left_next == '0);
      end
      PH_SP_B: begin
        res.sda = 1'b0;
      end
      default: begin
        res.scl = 1'b1;
      end
    endcase

    res.busy_res  = (phase_next != PH_IDLE);
    res.read_byte = res.read_valid ? shift_reg_next : 8'd0;
    res.ack_error = error_flag_next;
  end

  // Result queue toward the host.
  i2c_mra_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .push    (fire),
    .wr_data (res),
    .full    (out_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// ----- src/i2c_master_register_access_core.sv -----
// ----------------------------------------------------------------------------
// I2C master register access core
// Runs register write and read transactions against a 7-bit I2C device,
// at most one SCL/SDA pin phase per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive cmd and the operand fields, raise push; the
//   item is taken on a clock edge where full is low. cmd 1 or 2 starts a
//   write or read transaction, cmd 0 advances at most one pin phase, cmd 3 hands over
//   the next write byte while need_byte is reported.
//   Result side is a queue: while empty is low the oldest result (pin levels,
//   status, received byte) is on the result ports; pop takes it.
//   Every input item yields exactly one result, in order.
//   A result enters the result queue on the edge that takes its item and is
//   visible from the cycle after. Throughput: one item per cycle while the
//   result queue is not full; the bit engine sits between the two queues.
//   If the host stops popping, the result queue fills, the engine holds, and
//   then the item queue fills and full rises; nothing is dropped.
//   The user must write ack_timeout via cfg_valid/cfg_ready/cfg_data only
//   while idle, which the core does not enforce; cfg_ready is always high.
//   Synchronous reset empties both queues, returns the engine to idle with
//   released lines and loads ack_timeout with 250.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core
  import i2c_mra_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd,
  input  logic [6:0] dev_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] byte_count,
  input  logic [7:0] write_byte,
  input  logic       sda_in,
  output logic       empty,
  input  logic       pop,
  output logic       scl,
  output logic       sda,
  output logic       busy_res,
  output logic       need_byte,
  output logic [7:0] read_byte,
  output logic       read_valid,
  output logic       last_read,
  output logic       ack_error,
  output logic       done_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  item_t   item;
  logic    item_avail;
  logic    item_take;
  result_t result;

  // Command intake and classification.
  i2c_mra_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .dev_addr   (dev_addr),
    .reg_addr   (reg_addr),
    .byte_count (byte_count),
    .write_byte (write_byte),
    .sda_in     (sda_in),
    .item       (item),
    .item_avail (item_avail),
    .item_take  (item_take)
  );

  // Phase engine and result queue.
  i2c_mra_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_avail (item_avail),
    .item_take  (item_take),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  assign scl        = result.scl;
  assign sda        = result.sda;
  assign busy_res   = result.busy_res;
  assign need_byte  = result.need_byte;
  assign read_byte  = result.read_byte;
  assign read_valid = result.read_valid;
  assign last_read  = result.last_read;
  assign ack_error  = result.ack_error;
  assign done_res   = result.done_res;

endmodule

// ----- test/i2c_master_register_access_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access core: regression testbench
// Drives register write and read transfers one pin phase at a time, answers
// ACK and data bits on sda_in, and checks every result transaction against
// a phase-level model of the bit engine kept inside the testbench. Both
// queue sides stall at random, and the ACK timeout is changed between transfers.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core_tb;
  import i2c_mra_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int STALL_LIMIT  = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] cmd = CMD_CODE_TICK;
  logic [6:0] dev_addr = '0;
  logic [7:0] reg_addr = '0;
  logic [7:0] byte_count = '0;
  logic [7:0] write_byte = '0;
  logic       sda_in = 1'b1;
  logic       empty;
  logic       pop = 1'b0;
  logic       scl;
  logic       sda;
  logic       busy_res;
  logic       need_byte;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       last_read;
  logic       ack_error;
  logic       done_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  i2c_master_register_access_core dut (.*);

  // Clock generation.
  always #5 clk = ~clk;

  // Bus engine model state.
  phase_t     eng_phase = PH_IDLE;
  stage_t     eng_stage = STG_ADDR_W;
  logic [2:0] bit_cnt = '0;
  logic [7:0] shifter = '0;
  logic [7:0] bytes_rem = '0;
  logic [6:0] dev_q = '0;
  logic [7:0] reg_q = '0;
  logic       is_read = 1'b0;
  logic [7:0] nack_wait = '0;
  logic       err_flag = 1'b0;
  logic [7:0] ack_limit = ACK_TIMEOUT_RESET;

  result_t    expected_pins[$];
  int         mismatches = 0;
  int         items_sent = 0;
  bit         send_quiet = 1'b0;
  bit         pop_quiet = 1'b0;

  // Advance the engine model by one accepted item and return its pin result.
  task automatic advance_bus_phase(input logic [1:0] c, input logic [6:0] da,
                                   input logic [7:0] ra, input logic [7:0] bc,
                                   input logic [7:0] wb, input logic sdi,
                                   output result_t r);
    logic valid;
    logic last;
    logic done;
    logic need;
    logic acked;
    valid = 1'b0;
    last  = 1'b0;
    done  = 1'b0;
    need  = 1'b0;
    acked = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        if (c == CMD_CODE_WRITE || c == CMD_CODE_READ) begin
          dev_q     = da;
          reg_q     = ra;
          bytes_rem = bc;
          is_read   = (c == CMD_CODE_READ);
          err_flag  = 1'b0;
          nack_wait = '0;
          eng_stage = STG_ADDR_W;
          shifter   = {da, 1'b0};
          bit_cnt   = '0;
          eng_phase = PH_ST_A;
        end
      end
      PH_ST_A:    eng_phase = PH_ST_B;
      PH_ST_B:    eng_phase = PH_ST_C;
      PH_ST_C:    eng_phase = PH_TX_LO;
      PH_RS_PREP: eng_phase = PH_ST_A;
      PH_TX_LO:   eng_phase = PH_TX_HI;
      PH_TX_HI: begin
        if (bit_cnt == 3'd7) begin
          bit_cnt   = '0;
          nack_wait = '0;
          eng_phase = PH_ACK_LO;
        end else begin
          bit_cnt   = bit_cnt + 3'd1;
          eng_phase = PH_TX_LO;
        end
      end
      PH_ACK_LO: eng_phase = PH_ACK_HI;
      PH_ACK_HI: begin
        // A released SDA counts toward the timeout; past it the flag is set
        // and the transfer moves on as if acknowledged.
        if (!sdi) begin
          acked = 1'b1;
        end else if (nack_wait >= ack_limit) begin
          err_flag = 1'b1;
          acked    = 1'b1;
        end else begin
          nack_wait = nack_wait + 8'd1;
        end
        if (acked) begin
          case (eng_stage)
            STG_ADDR_W: begin
              shifter   = reg_q;
              bit_cnt   = '0;
              eng_stage = STG_REG;
              eng_phase = PH_TX_LO;
            end
            STG_REG: begin
              if (is_read) begin
                shifter   = {dev_q, 1'b1};
                bit_cnt   = '0;
                eng_stage = STG_ADDR_R;
                eng_phase = PH_RS_PREP;
              end else begin
                eng_stage = STG_DATA;
                eng_phase = (bytes_rem != 0) ? PH_WAIT_BYTE : PH_SP_A;
              end
            end
            STG_ADDR_R: begin
              if (bytes_rem != 0) begin
                shifter   = '0;
                bit_cnt   = '0;
                eng_phase = PH_RX_LO;
              end else begin
                eng_phase = PH_SP_A;
              end
            end
            default: eng_phase = (bytes_rem != 0) ? PH_WAIT_BYTE : PH_SP_A;
          endcase
        end
      end
      PH_WAIT_BYTE: begin
        if (c == CMD_CODE_SUPPLY) begin
          shifter   = wb;
          bytes_rem = bytes_rem - 8'd1;
          bit_cnt   = '0;
          eng_phase = PH_TX_LO;
        end
      end
      PH_RX_LO: eng_phase = PH_RX_HI;
      PH_RX_HI: begin
        shifter[3'd7 - bit_cnt] = shifter[3'd7 - bit_cnt] | sdi;
        if (bit_cnt == 3'd7) begin
          bytes_rem = bytes_rem - 8'd1;
          valid     = 1'b1;
          last      = (bytes_rem == 0);
          bit_cnt   = '0;
          eng_phase = PH_MACK_LO;
        end else begin
          bit_cnt   = bit_cnt + 3'd1;
          eng_phase = PH_RX_LO;
        end
      end
      PH_MACK_LO: eng_phase = PH_MACK_HI;
      PH_MACK_HI: begin
        if (bytes_rem != 0) begin
          shifter   = '0;
          bit_cnt   = '0;
          eng_phase = PH_RX_LO;
        end else begin
          eng_phase = PH_SP_A;
        end
      end
      PH_SP_A: eng_phase = PH_SP_B;
      PH_SP_B: begin
        eng_phase = PH_IDLE;
        done      = 1'b1;
      end
      default: eng_phase = PH_IDLE;
    endcase

    // Pin levels follow from the phase that was just entered.
    r     = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    case (eng_phase)
      PH_ST_B: begin
        r.sda = 1'b0;
      end
      PH_ST_C, PH_SP_A: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      PH_RS_PREP, PH_ACK_LO, PH_RX_LO: begin
        r.scl = 1'b0;
      end
      PH_TX_LO, PH_TX_HI: begin
        r.scl = (eng_phase == PH_TX_HI);
        r.sda = shifter[3'd7 - bit_cnt];
      end
      PH_WAIT_BYTE: begin
        r.scl = 1'b0;
        need  = 1'b1;
      end
      PH_MACK_LO, PH_MACK_HI: begin
        r.scl = (eng_phase == PH_MACK_HI);
        r.sda = (bytes_rem == 0);
      end
      PH_SP_B: begin
        r.sda = 1'b0;
      end
      default: ;
    endcase
    r.busy_res   = (eng_phase != PH_IDLE);
    r.need_byte  = need;
    r.read_byte  = valid ? shifter : 8'd0;
    r.read_valid = valid;
    r.last_read  = last;
    r.ack_error  = err_flag;
    r.done_res   = done;
  endtask

  // Send one item: optional idle gap, then hold push until the transaction.
  task automatic send_item(input logic [1:0] c, input logic [6:0] da,
                           input logic [7:0] ra, input logic [7:0] bc,
                           input logic [7:0] wb, input logic sdi);
    int      gap;
    result_t r;
    if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    cmd        <= c;
    dev_addr   <= da;
    reg_addr   <= ra;
    byte_count <= bc;
    write_byte <= wb;
    sda_in     <= sdi;
    @(posedge clk);
    while (full) @(posedge clk);
    advance_bus_phase(c, da, ra, bc, wb, sdi, r);
    expected_pins.push_back(r);
    items_sent++;
  endtask

  // Stop sending and wait until every expected result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_pins.size() != 0) @(posedge clk);
  endtask

  // Write the ACK timeout register while the engine is idle.
  task automatic write_ack_limit(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ack_limit = v;
  endtask

  // Run one register transfer from begin to STOP. The device side answers
  // each ACK slot with SDA released at nack_pct percent, and noise_pct
  // percent of the ticks carry a command the engine must treat as a tick.
  task automatic run_transfer(input logic [1:0] start_cmd, input logic [6:0] da,
                              input logic [7:0] ra, input logic [7:0] cnt,
                              input int nack_pct, input int noise_pct,
                              input int pause_pct);
    logic [1:0] c;
    logic       sdi;
    send_item(start_cmd, da, ra, cnt, 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
    while (eng_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < pause_pct) wait_drained();
      sdi = 1'($urandom_range(0, 1));
      if (eng_phase == PH_ACK_HI) sdi = ($urandom_range(0, 99) < nack_pct);
      c = CMD_CODE_TICK;
      if (eng_phase == PH_WAIT_BYTE) begin
        if ($urandom_range(0, 99) < 85) c = CMD_CODE_SUPPLY;
      end else if ($urandom_range(0, 99) < noise_pct) begin
        c = 2'($urandom_range(1, 3));
      end
      send_item(c, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sdi);
    end
  endtask

  // Ticks and byte supplies while idle leave the lines released.
  task automatic test_idle_commands();
    send_item(CMD_CODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(CMD_CODE_SUPPLY, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(CMD_CODE_TICK, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(CMD_CODE_SUPPLY, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
  endtask

  // Write transfers, including one with no data bytes.
  task automatic test_write_transfer();
    run_transfer(CMD_CODE_WRITE, 7'h7F, 8'hFF, 8'd0, 0, 0, 0);
    run_transfer(CMD_CODE_WRITE, 7'h00, 8'h00, 8'd2, 0, 0, 0);
  endtask

  // Read transfers, including one with no data bytes.
  task automatic test_read_transfer();
    run_transfer(CMD_CODE_READ, 7'h55, 8'hA5, 8'd0, 0, 0, 0);
    run_transfer(CMD_CODE_READ, 7'h2A, 8'h5A, 8'd3, 0, 0, 0);
  endtask

  // Begin and supply commands arriving when the engine cannot take them.
  task automatic test_busy_commands();
    run_transfer(CMD_CODE_WRITE, 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)), 8'd2, 0, 50, 0);
    run_transfer(CMD_CODE_READ, 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)), 8'd2, 0, 50, 0);
  endtask

  // ACK timeouts at the reset limit, a limit of one and a zero limit.
  task automatic test_ack_timeout();
    run_transfer(CMD_CODE_WRITE, 7'h11, 8'h22, 8'd0, 100, 0, 0);
    write_ack_limit(8'd1);
    run_transfer(CMD_CODE_WRITE, 7'h33, 8'h44, 8'd1, 100, 0, 0);
    run_transfer(CMD_CODE_READ, 7'h66, 8'h77, 8'd1, 100, 0, 0);
    write_ack_limit(8'd0);
    run_transfer(CMD_CODE_READ, 7'h0F, 8'hF0, 8'd2, 30, 0, 0);
  endtask

  // The sender stops now and then until the result queue has drained.
  task automatic test_drain_pause();
    run_transfer(CMD_CODE_READ, 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)), 8'd2, 10, 5, 10);
  endtask

  // Random transfers under a series of ACK timeout settings.
  task automatic test_random_traffic();
    logic [7:0] limits [5];
    int         stop_at;
    int         pick;
    int         nack;
    logic [7:0] cnt;
    limits = '{ACK_TIMEOUT_RESET, 8'd255, 8'd2, 8'd0, 8'($urandom_range(3, 254))};
    foreach (limits[i]) begin
      write_ack_limit(limits[i]);
      stop_at = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) cnt = 8'($urandom_range(0, 3));
        else if (pick < 97) cnt = 8'($urandom_range(4, 8));
        else cnt = 8'($urandom_range(9, 20));
        case ($urandom_range(0, 9))
          0:       nack = (limits[i] <= 8'd8) ? 100 : 0;
          1, 2:    nack = 25;
          default: nack = 0;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          send_item($urandom_range(0, 1) ? CMD_CODE_TICK : CMD_CODE_SUPPLY,
                    7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
        run_transfer($urandom_range(0, 1) ? CMD_CODE_READ : CMD_CODE_WRITE,
                     7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), cnt,
                     nack, $urandom_range(0, 1) ? 0 : 8,
                     ($urandom_range(0, 19) == 0) ? 5 : 0);
      end
    end
  endtask

  // Compare one field of a result and report a mismatch.
  function automatic void compare_field(input string name, input logic [7:0] e,
                                        input logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endfunction

  // Result side: random pop stalls, and a check of every popped transaction.
  initial begin : result_side
    int      gap;
    result_t got;
    result_t want;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) pop_quiet = !pop_quiet;
      gap = pop_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = {scl, sda, busy_res, need_byte, read_byte, read_valid, last_read,
             ack_error, done_res};
      if (expected_pins.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, got);
        mismatches++;
      end else begin
        want = expected_pins.pop_front();
        compare_field("scl", 8'(want.scl), 8'(got.scl));
        compare_field("sda", 8'(want.sda), 8'(got.sda));
        compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        compare_field("need_byte", 8'(want.need_byte), 8'(got.need_byte));
        compare_field("read_byte", want.read_byte, got.read_byte);
        compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
        compare_field("last_read", 8'(want.last_read), 8'(got.last_read));
        compare_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
        compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      end
    end
  end

  // Watchdog: ends the run when no transaction completes for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("i2c_master_register_access_core regression: fail");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_write_transfer();
    test_read_transfer();
    test_busy_commands();
    test_ack_timeout();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("i2c_master_register_access_core regression: pass");
    end else begin
      $display("i2c_master_register_access_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/i2c_mra_pkg.sv
src/i2c_mra_fifo.sv
src/i2c_mra_front.sv
src/i2c_mra_back.sv
src/i2c_master_register_access_core.sv
test/i2c_master_register_access_core_tb.sv
